/* rtl/core/crt_pkg.sv */
// Shared constants, types and handshake structs for the cadence rpm tracker.
`default_nettype none

package crt_pkg;

    // Field widths
    localparam int NOW_W      = 32;
    localparam int RPM_W      = 16;
    localparam int SECS_W     = 23;
    localparam int CNT_W      = 32;
    localparam int EMA_W      = 24;
    localparam int ALPHA_W    = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 72;
    localparam int PROD_W     = EMA_W + ALPHA_W;

    // Divider geometry: two quotient bits per step
    localparam int DIV_NUM_W  = 34;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_STEPS  = DIV_NUM_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Arithmetic constants
    localparam logic [DIV_NUM_W-1:0] RPM_NUMERATOR = DIV_NUM_W'(60000);
    localparam logic [DIV_DEN_W-1:0] MS_PER_SEC    = DIV_DEN_W'(1000);
    localparam logic [ALPHA_W-1:0]   ALPHA_DEFAULT = ALPHA_W'(25);
    localparam logic [ALPHA_W-1:0]   PCT_FULL      = ALPHA_W'(100);
    localparam logic [EMA_W:0]       EMA_HALF      = (EMA_W + 1)'(128);

    // Reset values of the configuration registers
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = ALPHA_W'(25);
    localparam logic [RPM_W-1:0]     CLAMP_RESET   = RPM_W'(250);

    // Item kinds carried on s_tuser
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_DROPOUT  = 2'd1,
        REG_ALPHA    = 2'd2,
        REG_CLAMP    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } crt_div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } crt_div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/crt_div.sv */
// Shared unsigned radix-4 restoring divider, two quotient bits per cycle.
`default_nettype none

module crt_div
    import crt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire crt_div_req_t req,
    output crt_div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;

    logic [DIV_DEN_W:0]   try_a, try_b;
    logic [DIV_DEN_W-1:0] rem_a;
    logic                 ge_a, ge_b;

    always_comb begin
        // first bit of the pair
        try_a = {rem_reg, num_reg[DIV_NUM_W-1]};
        ge_a  = try_a >= {1'b0, den_reg};
        rem_a = ge_a ? DIV_DEN_W'(try_a - {1'b0, den_reg}) : try_a[DIV_DEN_W-1:0];
        // second bit of the pair
        try_b = {rem_a, num_reg[DIV_NUM_W-2]};
        ge_b  = try_b >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            num_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[DIV_NUM_W-3:0], 2'b00};
            rem_next = ge_b ? DIV_DEN_W'(try_b - {1'b0, den_reg}) : try_b[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-3:0], ge_a, ge_b};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/cadence_rpm_tracker_top.sv */
// Top level of the cadence rpm tracker: handshakes, sequencer and tracker state.
`default_nettype none

// Pedal cadence tracker. Each request is a sensor edge (s_tuser = 0) or a time
// tick (s_tuser = 1) stamped with a wrapping ms time on s_tdata, and gives
// exactly one result. Edges after arming turn their gap into a rounded rpm
// (60000 + gap/2) / gap, clamped to rpm_clamp, which feeds a percent-alpha EMA
// kept at rpm * 256; bounced edges instead bump the dropped count and, past
// dropout, report seconds of silence as a tick would. Ticks zero the displayed
// rpm after the dropout time of silence and report whole seconds of silence
// beyond it. All divisions run on one shared radix-4 divider. An accepted
// edge that updates a running filter runs the gap division, the multiply
// states ST_MIX_MUL and ST_MIX_ADD, and the mix division; an edge that seeds
// the filter, a tick past dropout and a bounced edge past dropout run one
// division; everything else runs no division. s_tready is high only while the
// sequencer is idle; a finished result waits in the output register, so the
// next request can be taken while the previous result is still unclaimed.
// Configuration writes are taken at any edge with cfg_wr_en high and should
// only be issued while the block is idle.

module cadence_rpm_tracker_top
    import crt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] now_ms
    input  wire logic                  s_tuser,   // [0] func
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [15:0] rpm_out, [38:16] dropout_secs,
                                                  // [70:39] dropped_count, [71] zero
    output logic                       m_tuser,   // [0] edge_accepted
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RPM_DIV,
        ST_MIX_MUL,
        ST_MIX_ADD,
        ST_MIX_DIV,
        ST_SECS_DIV,
        ST_OUT
    } state_t;

    // control and configuration
    state_t               state_reg, state_next;
    logic [NOW_W-1:0]     debounce_reg, debounce_next;
    logic [NOW_W-1:0]     dropout_reg, dropout_next;
    logic [ALPHA_W-1:0]   alpha_reg, alpha_next;
    logic [RPM_W-1:0]     clamp_reg, clamp_next;

    // tracker state
    logic                 armed_reg, armed_next;
    logic [NOW_W-1:0]     last_edge_reg, last_edge_next;
    logic [EMA_W-1:0]     ema_reg, ema_next;
    logic [RPM_W-1:0]     rpm_reg, rpm_next;
    logic [CNT_W-1:0]     bounce_reg, bounce_next;

    // per-request working values
    logic                 accepted_reg, accepted_next;
    logic [SECS_W-1:0]    secs_reg, secs_next;
    logic [EMA_W-1:0]     sample_reg, sample_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    // divider request
    logic                 div_start_reg, div_start_next;
    logic [DIV_NUM_W-1:0] div_num_reg, div_num_next;
    logic [DIV_DEN_W-1:0] div_den_reg, div_den_next;

    // result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    crt_div_req_t         div_req;
    crt_div_rsp_t         div_rsp;

    logic [NOW_W-1:0]     gap;
    logic [NOW_W-1:0]     gap_nz;
    logic [ALPHA_W-1:0]   alpha_eff;
    logic [ALPHA_W-1:0]   alpha_rest;
    logic [RPM_W-1:0]     raw_rpm;
    logic [EMA_W:0]       ema_round;

    crt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_num_reg;
    assign div_req.divisor  = div_den_reg;

    always_comb begin
        // time since the last accepted edge, modulo 2^32
        gap    = s_tdata[NOW_W-1:0] - last_edge_reg;
        gap_nz = (gap == '0) ? NOW_W'(1) : gap;

        // zero means default weight, anything past 100 saturates
        if (alpha_reg == '0) begin
            alpha_eff = ALPHA_DEFAULT;
        end else if (alpha_reg > PCT_FULL) begin
            alpha_eff = PCT_FULL;
        end else begin
            alpha_eff = alpha_reg;
        end
        alpha_rest = PCT_FULL - alpha_eff;

        raw_rpm = (div_rsp.quotient > {(DIV_NUM_W - RPM_W)'(0), clamp_reg})
                ? clamp_reg : div_rsp.quotient[RPM_W-1:0];
        ema_round = {1'b0, div_rsp.quotient[EMA_W-1:0]} + EMA_HALF;

        state_next     = state_reg;
        debounce_next  = debounce_reg;
        dropout_next   = dropout_reg;
        alpha_next     = alpha_reg;
        clamp_next     = clamp_reg;
        armed_next     = armed_reg;
        last_edge_next = last_edge_reg;
        ema_next       = ema_reg;
        rpm_next       = rpm_reg;
        bounce_next    = bounce_reg;
        accepted_next  = accepted_reg;
        secs_next      = secs_reg;
        sample_next    = sample_reg;
        prod_next      = prod_reg;
        div_start_next = 1'b0;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_DEBOUNCE: debounce_next = cfg_wdata[NOW_W-1:0];
                REG_DROPOUT:  dropout_next  = cfg_wdata[NOW_W-1:0];
                REG_ALPHA:    alpha_next    = cfg_wdata[ALPHA_W-1:0];
                REG_CLAMP:    clamp_next    = cfg_wdata[RPM_W-1:0];
                default:      ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    accepted_next = 1'b0;
                    secs_next     = '0;
                    state_next    = ST_OUT;
                    if (s_tuser == FUNC_EDGE) begin
                        if (!armed_reg) begin
                            // first edge only arms
                            armed_next     = 1'b1;
                            last_edge_next = s_tdata[NOW_W-1:0];
                            accepted_next  = 1'b1;
                        end else if (gap < debounce_reg) begin
                            // bounce: count it, report silence as a tick would
                            bounce_next = bounce_reg + 1'b1;
                            if (gap >= dropout_reg) begin
                                div_start_next = 1'b1;
                                div_num_next   = DIV_NUM_W'(gap - dropout_reg);
                                div_den_next   = MS_PER_SEC;
                                state_next     = ST_SECS_DIV;
                            end
                        end else begin
                            // good edge: rpm = (60000 + g/2) / g
                            accepted_next  = 1'b1;
                            last_edge_next = s_tdata[NOW_W-1:0];
                            div_start_next = 1'b1;
                            div_num_next   = RPM_NUMERATOR
                                           + DIV_NUM_W'(gap_nz[NOW_W-1:1]);
                            div_den_next   = gap_nz;
                            state_next     = ST_RPM_DIV;
                        end
                    end else begin
                        if (armed_reg && gap >= dropout_reg) begin
                            rpm_next       = '0;
                            div_start_next = 1'b1;
                            div_num_next   = DIV_NUM_W'(gap - dropout_reg);
                            div_den_next   = MS_PER_SEC;
                            state_next     = ST_SECS_DIV;
                        end
                    end
                end
            end

            ST_RPM_DIV: begin
                if (div_rsp.done) begin
                    sample_next = {raw_rpm, 8'h00};
                    if (ema_reg == '0) begin
                        // empty filter takes the sample as is
                        ema_next   = {raw_rpm, 8'h00};
                        rpm_next   = raw_rpm;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_MIX_MUL;
                    end
                end
            end

            ST_MIX_MUL: begin
                prod_next  = PROD_W'(sample_reg) * PROD_W'(alpha_eff);
                state_next = ST_MIX_ADD;
            end

            ST_MIX_ADD: begin
                div_start_next = 1'b1;
                div_num_next   = DIV_NUM_W'(prod_reg)
                               + DIV_NUM_W'(PROD_W'(ema_reg) * PROD_W'(alpha_rest));
                div_den_next   = DIV_DEN_W'(PCT_FULL);
                state_next     = ST_MIX_DIV;
            end

            ST_MIX_DIV: begin
                if (div_rsp.done) begin
                    ema_next   = div_rsp.quotient[EMA_W-1:0];
                    rpm_next   = ema_round[EMA_W-1:8];
                    state_next = ST_OUT;
                end
            end

            ST_SECS_DIV: begin
                if (div_rsp.done) begin
                    secs_next  = div_rsp.quotient[SECS_W-1:0];
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = accepted_reg;
                    m_tdata_next  = {1'b0, bounce_reg, secs_reg, rpm_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            debounce_reg  <= '0;
            dropout_reg   <= '0;
            alpha_reg     <= ALPHA_RESET;
            clamp_reg     <= CLAMP_RESET;
            armed_reg     <= 1'b0;
            last_edge_reg <= '0;
            ema_reg       <= '0;
            rpm_reg       <= '0;
            bounce_reg    <= '0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            debounce_reg  <= debounce_next;
            dropout_reg   <= dropout_next;
            alpha_reg     <= alpha_next;
            clamp_reg     <= clamp_next;
            armed_reg     <= armed_next;
            last_edge_reg <= last_edge_next;
            ema_reg       <= ema_next;
            rpm_reg       <= rpm_next;
            bounce_reg    <= bounce_next;
            div_start_reg <= div_start_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        accepted_reg <= accepted_next;
        secs_reg     <= secs_next;
        sample_reg   <= sample_next;
        prod_reg     <= prod_next;
        div_num_reg  <= div_num_next;
        div_den_reg  <= div_den_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
